@@ sv/binary_trie_prefix_lookup_unit_defines.svh @@
// Assertion macros used by the checker file of the prefix lookup unit.
`ifndef BINARY_TRIE_PREFIX_LOOKUP_UNIT_DEFINES_SVH
`define BINARY_TRIE_PREFIX_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define BTPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define BTPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/btpl_pkg.sv @@
// Types, constants and codes of the binary trie prefix lookup unit.
package btpl_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int ADDR_BITS  = 32;

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int USED_W  = $clog2(NODE_COUNT + 1);
  localparam int DEPTH_W = $clog2(ADDR_BITS + 1);
  localparam int ABIT_W  = $clog2(ADDR_BITS);

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_REPLACED = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } walk_state_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [31:0] next_hop_in;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] next_hop_out;
    logic [31:0] stored_prefix;
  } out_item_t;

  typedef struct packed {
    logic [1:0][NODE_W-1:0] kid;
    logic                   valid;
    logic [31:0]            hop;
    logic [31:0]            addr;
  } node_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    node_t             wdata;
    logic [NODE_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ sv/btpl_node_ram.sv @@
// Node memory: one write port, one read port with registered data.
module btpl_node_ram (
  input  logic              clk,
  input  btpl_pkg::ram_req_t req,
  output btpl_pkg::node_t    rdata
);
  import btpl_pkg::*;

  node_t mem [NODE_COUNT];
  node_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/btpl_walker.sv @@
// Trie walker: one node per cycle for insert and search, node allocation.
module btpl_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  btpl_pkg::in_item_t  in_data,
  output logic                res_valid,
  input  logic                res_ready,
  output btpl_pkg::out_item_t res_data,
  output btpl_pkg::ram_req_t  ram_req,
  input  btpl_pkg::node_t     ram_rdata
);
  import btpl_pkg::*;

  walk_state_t        state_r, state_nxt;
  logic [NODE_W-1:0]  cur_r, cur_nxt;
  logic [DEPTH_W-1:0] d_r, d_nxt;
  logic [DEPTH_W-1:0] len_r, len_nxt;
  logic               mode_r, mode_nxt;
  logic [31:0]        addr_r, addr_nxt;
  logic [31:0]        hop_r, hop_nxt;
  logic               fresh_r, fresh_nxt;
  logic               found_r, found_nxt;
  logic [31:0]        best_hop_r, best_hop_nxt;
  logic [31:0]        best_addr_r, best_addr_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  logic               root_clean_r, root_clean_nxt;
  out_item_t          res_r, res_nxt;

  node_t              nd;
  node_t              wn;
  logic [DEPTH_W-1:0] pos;
  logic               bsel;
  logic [NODE_W-1:0]  kid;
  logic               take_here;
  logic [DEPTH_W-1:0] len_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= USED_W'(1);
      root_clean_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      root_clean_r <= root_clean_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    d_r         <= d_nxt;
    len_r       <= len_nxt;
    mode_r      <= mode_nxt;
    addr_r      <= addr_nxt;
    hop_r       <= hop_nxt;
    fresh_r     <= fresh_nxt;
    found_r     <= found_nxt;
    best_hop_r  <= best_hop_nxt;
    best_addr_r <= best_addr_nxt;
    res_r       <= res_nxt;
  end

  // Fresh nodes and the untouched root read as all zero.
  always_comb begin
    if (fresh_r || (root_clean_r && (cur_r == '0))) begin
      nd = '0;
    end else begin
      nd = ram_rdata;
    end
  end

  assign pos       = DEPTH_W'(ADDR_BITS - 1) - d_r;
  assign bsel      = addr_r[pos[ABIT_W-1:0]];
  assign kid       = nd.kid[bsel];
  assign take_here = (d_r >= len_r) && nd.valid;
  assign len_in    = (in_data.prefix_len > 6'(ADDR_BITS)) ? DEPTH_W'(ADDR_BITS)
                                                          : DEPTH_W'(in_data.prefix_len);

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    d_nxt          = d_r;
    len_nxt        = len_r;
    mode_nxt       = mode_r;
    addr_nxt       = addr_r;
    hop_nxt        = hop_r;
    fresh_nxt      = fresh_r;
    found_nxt      = found_r;
    best_hop_nxt   = best_hop_r;
    best_addr_nxt  = best_addr_r;
    used_nxt       = used_r;
    res_nxt        = res_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    wn             = nd;
    ram_req.we     = 1'b0;
    ram_req.waddr  = cur_r;
    ram_req.wdata  = nd;
    ram_req.raddr  = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // Root read issued now, data arrives with the first walk cycle.
          mode_nxt  = in_data.mode;
          addr_nxt  = in_data.address;
          len_nxt   = len_in;
          hop_nxt   = in_data.next_hop_in;
          cur_nxt   = '0;
          d_nxt     = '0;
          fresh_nxt = 1'b0;
          found_nxt = 1'b0;
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        res_nxt = '{status: ST_MISS, next_hop_out: '0, stored_prefix: '0};
        if (mode_r) begin
          if (d_r == len_r) begin
            wn.valid      = 1'b1;
            wn.hop        = hop_r;
            wn.addr       = addr_r;
            ram_req.we    = 1'b1;
            ram_req.wdata = wn;
            res_nxt.status = nd.valid ? ST_REPLACED : ST_INSERTED;
            state_nxt     = S_HOLD;
          end else if (kid != '0) begin
            ram_req.raddr = kid;
            cur_nxt       = kid;
            d_nxt         = d_r + 1'b1;
            fresh_nxt     = 1'b0;
          end else if (used_r == USED_W'(NODE_COUNT)) begin
            // Write back unchanged so a fresh node left behind reads as cleared.
            ram_req.we     = 1'b1;
            res_nxt.status = ST_FULL;
            state_nxt      = S_HOLD;
          end else begin
            wn.kid[bsel]  = used_r[NODE_W-1:0];
            ram_req.we    = 1'b1;
            ram_req.wdata = wn;
            cur_nxt       = used_r[NODE_W-1:0];
            used_nxt      = used_r + 1'b1;
            d_nxt         = d_r + 1'b1;
            fresh_nxt     = 1'b1;
          end
        end else begin
          if (take_here) begin
            found_nxt     = 1'b1;
            best_hop_nxt  = nd.hop;
            best_addr_nxt = nd.addr;
          end
          if ((d_r == DEPTH_W'(ADDR_BITS)) || (kid == '0)) begin
            state_nxt = S_HOLD;
            if ((d_r < len_r) || !(found_r || take_here)) begin
              res_nxt.status = ST_MISS;
            end else begin
              res_nxt.status        = ST_HIT;
              res_nxt.next_hop_out  = take_here ? nd.hop : best_hop_r;
              res_nxt.stored_prefix = take_here ? nd.addr : best_addr_r;
            end
          end else begin
            ram_req.raddr = kid;
            cur_nxt       = kid;
            d_nxt         = d_r + 1'b1;
          end
        end
      end

      S_HOLD: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    root_clean_nxt = root_clean_r && !(ram_req.we && (ram_req.waddr == '0));
  end

  assign res_data = res_r;

endmodule

@@ sv/binary_trie_prefix_lookup_unit.sv @@
// Longest-prefix match over a one-bit binary trie of up to NODE_COUNT nodes:
// an item is accepted when the unit is idle, then walks the trie one level per
// cycle, one node memory read per level (up to 33 levels for a full-depth
// search, prefix_len levels (capped at 32) plus one for an insert). Its result
// lands in a holding register at the end of the last walk cycle and moves to
// the output register once that register is empty or being read, and the next
// item can be taken in the first cycle that the result shows. The node memory
// read port, with its registered data, sets the pace. The root reads as empty
// after reset with no clearing pass; a new input item is taken while the
// previous result still waits in the output register.
module binary_trie_prefix_lookup_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  btpl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output btpl_pkg::out_item_t out_data
);
  import btpl_pkg::*;

  ram_req_t  ram_req;
  node_t     ram_rdata;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  btpl_node_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  btpl_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (out_ready) begin
      // Drop the slot once its transfer completes.
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/btpl_checker.sv @@
// Port-level checks of the prefix lookup unit and their bind.
`include "binary_trie_prefix_lookup_unit_defines.svh"

module btpl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input btpl_pkg::out_item_t out_data
);
  import btpl_pkg::*;

  `BTPL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `BTPL_ASSERT_NOW(a_miss_zero, out_valid && (out_data.status != ST_HIT), (out_data.next_hop_out == '0) && (out_data.stored_prefix == '0), "non-hit result carries data")
  `BTPL_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "second item taken during a walk")

endmodule

bind binary_trie_prefix_lookup_unit btpl_checker u_btpl_checker (.*);

@@ sim/tb_top.sv @@
// Testbench for the binary trie prefix lookup unit: directed and random traffic with a trie predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import btpl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_OFF_LEN   = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  binary_trie_prefix_lookup_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the node memory.
  int          trie_kid   [NODE_COUNT][2];
  bit          trie_valid [NODE_COUNT];
  logic [31:0] trie_hop   [NODE_COUNT];
  logic [31:0] trie_addr  [NODE_COUNT];
  int          trie_used;

  out_item_t   expected_answers[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  // Route families keep the random inserts inside the node pool.
  logic [31:0] route_base [8];
  logic [7:0]  route_tail [8];

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic in_item_t lookup_req(input logic mode, input logic [31:0] address,
                                          input logic [5:0] len, input logic [31:0] hop);
    in_item_t it;
    it.mode        = mode;
    it.address     = address;
    it.prefix_len  = len;
    it.next_hop_in = hop;
    return it;
  endfunction

  function automatic out_item_t predict_lookup(input in_item_t it);
    out_item_t r;
    int        len;
    int        depth;
    int        cur;
    int        nxt;
    int        best;
    bit        found;
    bit        stop;
    r = '0;
    len = (it.prefix_len > ADDR_BITS) ? ADDR_BITS : int'(it.prefix_len);
    cur = 0;
    if (it.mode) begin
      for (depth = 0; depth < len; depth++) begin
        nxt = trie_kid[cur][it.address[ADDR_BITS-1-depth]];
        if (nxt == 0) begin
          if (trie_used >= NODE_COUNT) begin
            // keep the nodes made so far
            r.status = ST_FULL;
            return r;
          end
          nxt = trie_used;
          trie_used++;
          trie_kid[nxt][0] = 0;
          trie_kid[nxt][1] = 0;
          trie_valid[nxt]  = 1'b0;
          trie_hop[nxt]    = '0;
          trie_addr[nxt]   = '0;
          trie_kid[cur][it.address[ADDR_BITS-1-depth]] = nxt;
        end
        cur = nxt;
      end
      r.status = trie_valid[cur] ? ST_REPLACED : ST_INSERTED;
      trie_valid[cur] = 1'b1;
      trie_hop[cur]   = it.next_hop_in;
      trie_addr[cur]  = it.address;
      return r;
    end
    for (depth = 0; depth < len; depth++) begin
      nxt = trie_kid[cur][it.address[ADDR_BITS-1-depth]];
      if (nxt == 0) begin
        r.status = ST_MISS;
        return r;
      end
      cur = nxt;
    end
    // continue past the hint and remember the deepest stored entry
    found = 1'b0;
    best  = 0;
    stop  = 1'b0;
    while (!stop) begin
      if (trie_valid[cur]) begin
        found = 1'b1;
        best  = cur;
      end
      if (depth >= ADDR_BITS) begin
        stop = 1'b1;
      end else begin
        nxt = trie_kid[cur][it.address[ADDR_BITS-1-depth]];
        if (nxt == 0) begin
          stop = 1'b1;
        end else begin
          cur = nxt;
          depth++;
        end
      end
    end
    if (!found) begin
      r.status = ST_MISS;
    end else begin
      r.status        = ST_HIT;
      r.next_hop_out  = trie_hop[best];
      r.stored_prefix = trie_addr[best];
    end
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    it.next_hop_in = $urandom;
    it.address = {route_base[$urandom_range(7)][31:8], route_tail[$urandom_range(7)]};
    if (pick < 45) begin
      it.mode = 1'b1;
      it.prefix_len = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33))
                                               : 6'($urandom_range(32));
    end else begin
      it.mode = 1'b0;
      if (pick >= 85) begin
        it.address = $urandom;
      end else if ($urandom_range(3) == 0) begin
        it.address ^= 32'd1 << $urandom_range(31);
      end
      case ($urandom_range(9))
        0:       it.prefix_len = 6'($urandom_range(63, 33));
        1, 2, 3: it.prefix_len = 6'($urandom_range(8));
        default: it.prefix_len = 6'($urandom_range(32));
      endcase
    end
    return it;
  endfunction

  // Enter and leave at a falling edge; valid stays up between back-to-back items.
  task automatic send_item(input in_item_t item, output out_item_t predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predicted = predict_lookup(item);
    expected_answers.push_back(predicted);
    @(negedge clk);
  endtask

  task automatic random_phase(input int count);
    out_item_t ans;
    repeat (count) send_item(random_item(), ans);
  endtask

  task automatic test_empty_trie();
    out_item_t ans;
    send_item(lookup_req(1'b0, 32'h0000_0000, 6'd0, 32'h0), ans);
    send_item(lookup_req(1'b0, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF), ans);
    send_item(lookup_req(1'b0, $urandom, 6'd63, $urandom), ans);
  endtask

  task automatic test_root_prefix();
    out_item_t ans;
    send_item(lookup_req(1'b1, $urandom, 6'd0, 32'h0000_0000), ans);
    send_item(lookup_req(1'b0, $urandom, 6'd0, $urandom), ans);
    send_item(lookup_req(1'b0, $urandom, 6'd5, $urandom), ans);
  endtask

  task automatic test_full_depth();
    out_item_t ans;
    send_item(lookup_req(1'b1, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF), ans);
    // over-long length lands on the same node
    send_item(lookup_req(1'b1, 32'hFFFF_FFFF, 6'd63, 32'h1234_5678), ans);
    send_item(lookup_req(1'b0, 32'hFFFF_FFFF, 6'd0, 32'h0), ans);
    send_item(lookup_req(1'b0, 32'hFFFF_FFFF, 6'd32, 32'h0), ans);
    send_item(lookup_req(1'b0, 32'hFFFF_FFFE, 6'd32, 32'h0), ans);
    send_item(lookup_req(1'b0, 32'hFFFF_FFFE, 6'd0, 32'h0), ans);
  endtask

  task automatic test_longest_match();
    out_item_t ans;
    send_item(lookup_req(1'b1, 32'h0A00_0000, 6'd8, $urandom), ans);
    send_item(lookup_req(1'b1, 32'h0A01_0000, 6'd16, $urandom), ans);
    send_item(lookup_req(1'b1, 32'h0A01_0000, 6'd16, $urandom), ans);
    send_item(lookup_req(1'b0, 32'h0A01_0203, 6'd0, 32'h0), ans);
    send_item(lookup_req(1'b0, 32'h0A01_0203, 6'd9, 32'h0), ans);
    send_item(lookup_req(1'b0, 32'h0A01_0203, 6'd17, 32'h0), ans);
    send_item(lookup_req(1'b0, 32'h0AFF_0000, 6'd8, 32'h0), ans);
    send_item(lookup_req(1'b0, 32'h0000_0000, 6'd32, 32'h0), ans);
    send_item(lookup_req(1'b1, 32'h0000_0000, 6'd32, 32'h0), ans);
    send_item(lookup_req(1'b0, 32'h0000_0000, 6'd32, 32'h0), ans);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 12;
    recv_idle_pct = 48;
    random_phase(650);
    send_idle_pct = 48;
    recv_idle_pct = 12;
    random_phase(650);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(650);
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    random_phase(40);
  endtask

  task automatic test_pool_exhaust();
    out_item_t   ans;
    in_item_t    item;
    logic [31:0] last_addr;
    int          full_seen;
    full_seen = 0;
    last_addr = route_base[0];
    while (full_seen < 5) begin
      item = lookup_req(1'b1, $urandom, 6'd32, $urandom);
      send_item(item, ans);
      if (ans.status == ST_FULL) full_seen++;
      else last_addr = item.address;
      send_item(lookup_req(1'b0, item.address, 6'($urandom_range(32)), $urandom), ans);
    end
    // no allocation needed: replace and shorter prefix still succeed
    send_item(lookup_req(1'b1, last_addr, 6'd32, $urandom), ans);
    send_item(lookup_req(1'b1, last_addr, 6'd20, $urandom), ans);
    send_item(lookup_req(1'b0, last_addr, 6'd0, 32'h0), ans);
    send_item(lookup_req(1'b0, last_addr, 6'd32, 32'h0), ans);
    random_phase(100);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $error("result transfer with nothing expected: status %0d", out_data.status);
        mismatch_count++;
      end else begin
        want = expected_answers.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.next_hop_out !== want.next_hop_out) begin
          $error("next_hop_out: expected %h, got %h", want.next_hop_out,
                 out_data.next_hop_out);
          mismatch_count++;
        end
        if (out_data.stored_prefix !== want.stored_prefix) begin
          $error("stored_prefix: expected %h, got %h", want.stored_prefix,
                 out_data.stored_prefix);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("binary_trie_prefix_lookup_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) begin
      route_base[i] = $urandom;
      route_tail[i] = 8'($urandom);
    end
    trie_kid[0][0] = 0;
    trie_kid[0][1] = 0;
    trie_valid[0]  = 1'b0;
    trie_hop[0]    = '0;
    trie_addr[0]   = '0;
    trie_used      = 1;

    send_idle_pct = 12;
    recv_idle_pct = 48;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_trie();
    test_root_prefix();
    test_full_depth();
    test_longest_match();
    test_random_traffic();
    test_backpressure();
    test_pool_exhaust();

    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("binary_trie_prefix_lookup_unit test passed");
    end else begin
      $display("binary_trie_prefix_lookup_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/btpl_pkg.sv
sv/btpl_node_ram.sv
sv/btpl_walker.sv
sv/binary_trie_prefix_lookup_unit.sv
sv/btpl_checker.sv
sim/tb_top.sv
